FILE: hdl/psc_pkg.sv
// ============================================================================
// psc_pkg: shared types and constants of the palindromic substring counter
// Sizes of the cell row, the popcount groups and the running total, and the
// structs that travel between the cells, the tally stage and the top level.
// ============================================================================
package psc_pkg;

    // Longest string that is stored; later characters are dropped
    localparam int MAX_LEN    = 64;
    localparam int CHAR_W     = 8;
    localparam int TOTAL_W    = 12;
    localparam int CNT_W      = $clog2(MAX_LEN + 1);

    // Popcount is split into registered groups of eight cells
    localparam int GRP_SIZE   = 8;
    localparam int GRP_W      = $clog2(GRP_SIZE + 1);
    localparam int NUM_GRP    = (MAX_LEN + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_LEN    = NUM_GRP * GRP_SIZE;

    // Largest total the block can report
    localparam int FULL_TOTAL = MAX_LEN * (MAX_LEN + 1) / 2;
    localparam int TOTAL_MAX  = (2 ** TOTAL_W) - 1;
    localparam int TOTAL_CAP  = (FULL_TOTAL > TOTAL_MAX) ? TOTAL_MAX : FULL_TOTAL;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [GRP_W-1:0]   t_grp_cnt;

    // What one cell shows its neighbors: write token and palindrome bit
    typedef struct packed {
        logic tok;
        logic pal;
    } t_link;

    // Broadcast to every cell for the current beat
    typedef struct packed {
        logic  take;
        logic  fresh;
        t_char chr;
    } t_cell_ctl;

    // One accepted beat on its way to the tally stage
    typedef struct packed {
        logic valid;
        logic took;
        logic last;
        logic ovf;
    } t_stage;

    // Result register contents
    typedef struct packed {
        logic   valid;
        t_total count;
        logic   ovf;
    } t_result;

endpackage

FILE: hdl/psc_in_if.sv
// ============================================================================
// psc_in_if: character input channel
// Valid/ready channel carrying one character and its end-of-string mark.
// ============================================================================
interface psc_in_if;
    import psc_pkg::*;

    logic  valid;
    logic  ready;
    t_char character;
    logic  is_last;

    modport source (output valid, output character, output is_last, input ready);
    modport sink   (input valid, input character, input is_last, output ready);

endinterface

FILE: hdl/psc_out_if.sv
// ============================================================================
// psc_out_if: result output channel
// Valid/ready channel carrying the palindrome count and the overflow flag.
// ============================================================================
interface psc_out_if;
    import psc_pkg::*;

    logic   valid;
    logic   ready;
    t_total palindrome_count;
    logic   overflow;

    modport source (output valid, output palindrome_count, output overflow, input ready);
    modport sink   (input valid, input palindrome_count, input overflow, output ready);

endinterface

FILE: hdl/psc_cell.sv
// ============================================================================
// psc_cell: one start position of the palindrome cell row
// Holds one stored character, a write token, a used flag and the palindrome
// bit for its start position; reads the token and bit of its upper neighbor.
// ============================================================================
module psc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psc_pkg::t_cell_ctl i_ctl,
    input  logic               i_first,
    input  logic               i_lo_tok,
    input  psc_pkg::t_link     i_hi,
    output psc_pkg::t_link     o_link,
    output logic               o_hit
);
    import psc_pkg::*;

    t_char r_char;
    logic  r_tok;
    logic  r_used;
    logic  r_pal;

    logic  w_tok;
    logic  w_used;
    logic  w_pal;
    logic  w_same;
    logic  w_inner;
    logic  w_active;
    logic  n_pal;

    // Treat the cell as empty right after the end of a string
    assign w_tok  = i_ctl.fresh ? i_first : r_tok;
    assign w_used = i_ctl.fresh ? 1'b0 : r_used;
    assign w_pal  = i_ctl.fresh ? 1'b0 : r_pal;

    // New bit: ends match and the inner part is short or a palindrome
    assign w_same   = w_tok | (r_char == i_ctl.chr);
    assign w_inner  = w_tok | i_hi.tok | i_hi.pal;
    assign w_active = w_used | w_tok;
    assign n_pal    = w_active & w_same & w_inner;

    assign o_link.tok = w_tok;
    assign o_link.pal = w_pal;
    assign o_hit      = r_pal;

    // Store the character at the write position
    always_ff @(posedge i_clk) begin
        if (i_ctl.take && w_tok) begin
            r_char <= i_ctl.chr;
        end
    end

    // Advance the token and update the palindrome bit on a stored beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_used <= 1'b0;
            r_pal  <= 1'b0;
        end else if (i_ctl.take) begin
            r_tok  <= i_lo_tok;
            r_used <= w_active;
            r_pal  <= n_pal;
        end
    end

endmodule

FILE: hdl/psc_tally.sv
// ============================================================================
// psc_tally: popcount and running total
// Sums the palindrome bits in registered groups of eight, adds the group
// sums to the saturating running total and loads the result register.
// ============================================================================
module psc_tally (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  psc_pkg::t_stage              i_s1,
    input  logic [psc_pkg::MAX_LEN-1:0]  i_hits,
    output psc_pkg::t_result             o_res
);
    import psc_pkg::*;

    t_stage               r_s2;
    t_grp_cnt             r_part [NUM_GRP];
    t_total               r_total;
    t_result              r_res;

    logic [PAD_LEN-1:0]   w_pad;
    t_grp_cnt             w_part [NUM_GRP];
    t_cnt                 w_cnt;
    logic [TOTAL_W:0]     w_sum;
    t_total               w_next;

    // Mask the bits of a dropped beat and pad to whole groups
    assign w_pad = i_s1.took ? PAD_LEN'(i_hits) : '0;

    // Count each group of eight
    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            w_part[g] = '0;
            for (int b = 0; b < GRP_SIZE; b++) begin
                w_part[g] = w_part[g] + GRP_W'(w_pad[g*GRP_SIZE + b]);
            end
        end
    end

    // Register the group sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_part <= w_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else if (i_en) begin
            r_s2 <= i_s1;
        end
    end

    // Add the group sums to the total, saturating at full scale
    always_comb begin
        w_cnt = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            w_cnt = w_cnt + CNT_W'(r_part[g]);
        end
    end

    assign w_sum  = {1'b0, r_total} + (TOTAL_W + 1)'(w_cnt);
    assign w_next = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];

    // Update the total; restart it after the last beat of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_en && r_s2.valid) begin
            r_total <= r_s2.last ? '0 : w_next;
        end
    end

    // Load the result register on the last beat of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_res.valid <= r_s2.valid & r_s2.last;
            if (r_s2.valid && r_s2.last) begin
                r_res.count <= w_next;
                r_res.ovf   <= r_s2.ovf;
            end
        end
    end

    assign o_res = r_res;

    // A result appears only after a last beat left the group stage
    a_res_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res.valid) |-> $past(r_s2.valid && r_s2.last))
        else $error("result without a last beat");

    // The reported count never exceeds the most a full string can hold
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.valid |-> (r_res.count <= TOTAL_W'(TOTAL_CAP)))
        else $error("palindrome count beyond bound");

    // The running total stays within the same bound
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOTAL_W'(TOTAL_CAP))
        else $error("running total beyond bound");

endmodule

FILE: hdl/palindromic_substring_counter_core.sv
// ============================================================================
// palindromic_substring_counter_core: streaming palindromic substring count
// Row of cells, one per start position, followed by a popcount/total stage.
// ============================================================================
// The block takes one character per cycle and reports, for each string, the
// number of its palindromic substrings after the beat that carries is_last:
// the cell row updates its palindrome bits, the group sums are registered,
// and the total is loaded into the result register. Each cell compares its
// stored character with the new one and reads the bit of its neighbor, so
// the row takes a new character on every accepted beat. Input is stalled
// only while a result waits in the output register and the sink does not
// take it. Up to MAX_LEN (64) characters are stored; further characters of
// the same string are dropped and set the overflow flag of its result.
// The next string may start in the cycle right after a last character.
module palindromic_substring_counter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psc_in_if.sink     i_in,
    psc_out_if.source  o_out
);
    import psc_pkg::*;

    logic               r_fresh;
    logic               r_full;
    logic               r_ovf;
    t_stage             r_s1;

    logic               w_en;
    logic               w_acc;
    logic               w_full;
    logic               w_ovf;
    logic               w_take;
    t_cell_ctl          w_ctl;
    t_link              w_link [MAX_LEN];
    logic [MAX_LEN-1:0] w_hit;
    logic [MAX_LEN-1:0] w_tok;
    t_result            w_res;

    // Advance the whole pipe unless a result is stuck in the output register
    assign w_en       = !w_res.valid || o_out.ready;
    assign i_in.ready = w_en;
    assign w_acc      = i_in.valid & w_en;

    // Forget the previous string right after its last beat
    assign w_full = !r_fresh & r_full;
    assign w_ovf  = !r_fresh & r_ovf;
    assign w_take = w_acc & !w_full;

    assign w_ctl.take  = w_take;
    assign w_ctl.fresh = r_fresh;
    assign w_ctl.chr   = i_in.character;

    // Build the cell row; tokens move up, palindrome bits are read downward
    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        t_link w_hi;
        logic  w_lo_tok;

        if (j == MAX_LEN - 1) begin : g_top
            assign w_hi = '0;
        end else begin : g_mid
            assign w_hi = w_link[j+1];
        end

        if (j == 0) begin : g_bot
            assign w_lo_tok = 1'b0;
        end else begin : g_up
            assign w_lo_tok = w_link[j-1].tok;
        end

        psc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_first  ((j == 0) ? 1'b1 : 1'b0),
            .i_lo_tok (w_lo_tok),
            .i_hi     (w_hi),
            .o_link   (w_link[j]),
            .o_hit    (w_hit[j])
        );

        assign w_tok[j] = w_link[j].tok;
    end

    // Track end of string, a full row and dropped characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= 1'b1;
            r_full  <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (w_acc) begin
            r_fresh <= i_in.is_last;
            r_full  <= w_full | (w_take & w_link[MAX_LEN-1].tok);
            r_ovf   <= w_ovf | w_full;
        end
    end

    // Hand the beat to the tally stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (w_en) begin
            r_s1.valid <= w_acc;
            r_s1.took  <= w_take;
            r_s1.last  <= i_in.is_last;
            r_s1.ovf   <= w_ovf | w_full;
        end
    end

    psc_tally u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_s1    (r_s1),
        .i_hits  (w_hit),
        .o_res   (w_res)
    );

    assign o_out.valid            = w_res.valid;
    assign o_out.palindrome_count = w_res.count;
    assign o_out.overflow         = w_res.ovf;

    // At most one cell holds the write token
    a_tok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one write token");

    // A full row has no write position left
    a_full_no_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_fresh && r_full) |-> (w_tok == '0))
        else $error("write token present in a full row");

    // A dropped beat that is not the last marks the string as overflowed
    a_drop_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_full && !i_in.is_last) |=> (r_ovf && !r_fresh))
        else $error("dropped character without overflow");

endmodule

FILE: tb/psc_count_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// psc_count_checker: result checker for the palindromic substring counter
// Watches the character and result channels, keeps its own copy of the
// palindrome bits, stored characters and running total, and compares every
// result beat field by field with the oldest predicted result.
// ============================================================================
module psc_count_checker
    import psc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    psc_in_if     i_in,
    psc_out_if    i_out,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked,
    output int    o_overflows,
    output int    o_top_count
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        t_total count;
        logic   ovf;
    } t_count_result;

    // Predicted string state
    t_char              seen_chars [MAX_LEN];
    logic [MAX_LEN-1:0] pal_start;
    int                 seen_len;
    int                 pal_total;
    logic               dropped;
    t_count_result      due_results [$];

    int fails;
    int checked;
    int overflows;
    int top_count;

    assign o_fail_count = fails;
    assign o_checked    = checked;
    assign o_overflows  = overflows;
    assign o_top_count  = top_count;

    // Drop the current string
    task automatic clear_string();
        pal_start = '0;
        seen_len  = 0;
        pal_total = 0;
        dropped   = 1'b0;
        for (int j = 0; j < MAX_LEN; j++) begin
            seen_chars[j] = '0;
        end
    endtask

    // Store one character and refresh the palindrome bit of every start
    task automatic absorb_char(input t_char c);
        logic [MAX_LEN-1:0] prev;
        logic               inner;
        int                 hits;
        prev = pal_start;
        hits = 0;
        seen_chars[seen_len] = c;
        for (int j = 0; j < MAX_LEN; j++) begin
            if (j <= seen_len) begin
                if (seen_len - j <= 1) begin
                    inner = 1'b1;
                end else if (j + 1 < MAX_LEN) begin
                    inner = prev[j+1];
                end else begin
                    inner = 1'b0;
                end
                pal_start[j] = (seen_chars[j] == c) && inner;
            end else begin
                pal_start[j] = 1'b0;
            end
            hits += int'(pal_start[j]);
        end
        seen_len++;
        pal_total = (pal_total + hits > TOTAL_MAX) ? TOTAL_MAX : pal_total + hits;
    endtask

    // Compare one result beat with the oldest prediction
    task automatic check_result(input t_total count, input logic ovf);
        t_count_result want;
        if (due_results.size() == 0) begin
            if (fails < REPORT_MAX) begin
                $display("[%0t] unexpected result beat: count=%0d overflow=%0b",
                         $realtime, count, ovf);
            end
            fails++;
        end else begin
            want = due_results.pop_front();
            if (count !== want.count || ovf !== want.ovf) begin
                if (fails < REPORT_MAX) begin
                    $display("[%0t] result mismatch: count exp=%0d got=%0d, overflow exp=%0b got=%0b",
                             $realtime, want.count, count, want.ovf, ovf);
                end
                fails++;
            end
        end
        checked++;
        if (ovf === 1'b1) begin
            overflows++;
        end
        if (int'(count) > top_count) begin
            top_count = int'(count);
        end
    endtask

    // Track both channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_string();
            due_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                check_result(i_out.palindrome_count, i_out.overflow);
            end
            if (i_in.valid && i_in.ready) begin
                if (seen_len < MAX_LEN) begin
                    absorb_char(i_in.character);
                end else begin
                    dropped = 1'b1;
                end
                if (i_in.is_last) begin
                    due_results.push_back('{count: t_total'(pal_total), ovf: dropped});
                    clear_string();
                end
            end
        end
        o_pending <= due_results.size();
    end

    initial begin
        fails     = 0;
        checked   = 0;
        overflows = 0;
        top_count = 0;
        o_pending = 0;
        clear_string();
    end

endmodule

FILE: tb/tb_palindromic_substring_counter_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_palindromic_substring_counter_core: testbench of the counter core
// Sends short directed strings, boundary strings of full and excess length,
// then random strings with random gaps on the input and random stalls on the
// output; a checker beside the block predicts and compares each result.
// ============================================================================
module tb_palindromic_substring_counter_core;
    import psc_pkg::*;

    localparam int ITEM_TARGET = 450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int WAIT_MAX    = 14;
    localparam int DRAIN_WAIT  = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psc_in_if  in_ch ();
    psc_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;
    int overflows;
    int top_count;

    bit    send_quiet;
    bit    take_quiet;
    int    chars_sent;
    int    strings_sent;
    int    cycles;
    t_char word [$];

    palindromic_substring_counter_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    psc_count_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_overflows  (overflows),
        .o_top_count  (top_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding", cycles, pending);
            $display("** palindromic_substring_counter_core: FAILED **");
            $finish;
        end
    end

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    // Drive one character beat and hold it until accepted
    task automatic send_char(input t_char c, input logic last);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.character <= c;
        in_ch.is_last   <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    // Send the word, marking its final character
    task automatic send_word();
        for (int k = 0; k < word.size(); k++) begin
            send_char(word[k], k == word.size() - 1);
        end
        strings_sent++;
        if ($urandom_range(0, 5) == 0) begin
            send_quiet = !send_quiet;
        end
    endtask

    task automatic set_word(input t_char a [$]);
        word = a;
    endtask

    // Fill the word with characters from a narrow alphabet
    task automatic narrow_word(input int len, input int spread);
        t_char base;
        base = t_char'($urandom);
        word.delete();
        for (int k = 0; k < len; k++) begin
            word.push_back(base ^ t_char'($urandom_range(0, spread)));
        end
    endtask

    // Build one random word of a randomly chosen shape
    task automatic random_word();
        int    kind;
        int    half;
        t_char base;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            narrow_word($urandom_range(1, 16), $urandom_range(1, 3));
        end else if (kind < 85) begin
            word.delete();
            repeat ($urandom_range(1, 24)) word.push_back(t_char'($urandom));
        end else if (kind < 95) begin
            // mirror a random half, with or without a middle character
            half = $urandom_range(1, 15);
            narrow_word(half, $urandom_range(1, 7));
            if ($urandom_range(0, 1) == 1) begin
                word.push_back(t_char'($urandom));
            end
            for (int k = half - 1; k >= 0; k--) begin
                word.push_back(word[k]);
            end
        end else if (kind < 97) begin
            narrow_word(MAX_LEN, 1);
        end else if (kind < 98) begin
            narrow_word(MAX_LEN, 0);
        end else begin
            narrow_word(MAX_LEN + $urandom_range(1, 8), $urandom_range(0, 1));
        end
    endtask

    // Sink side: stall a random number of cycles before each result beat
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        take_quiet   = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(take_quiet);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
            if ($urandom_range(0, 5) == 0) begin
                take_quiet = !take_quiet;
            end
        end
    end

    // Source side and verdict
    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.character = '0;
        in_ch.is_last   = 1'b0;
        send_quiet      = 1'b0;
        chars_sent      = 0;
        strings_sent    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings: single character, byte extremes, even and odd palindromes
        set_word('{8'h61});                     send_word();
        set_word('{8'h00, 8'hFF, 8'h00});       send_word();
        set_word('{8'hFF, 8'hFF});              send_word();
        set_word('{8'h61, 8'h62, 8'h62, 8'h61}); send_word();
        set_word('{8'h55, 8'hAA, 8'h55, 8'hAA}); send_word();
        set_word('{8'h00, 8'h00, 8'h00});       send_word();
        set_word('{8'h12, 8'h34});              send_word();

        // Boundary strings: full length of one character, then too long
        narrow_word(MAX_LEN, 0);     send_word();
        narrow_word(MAX_LEN + 2, 1); send_word();

        while (chars_sent < ITEM_TARGET) begin
            random_word();
            send_word();
        end
        in_ch.valid <= 1'b0;

        // Drain outstanding results
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d characters in %0d strings; checked %0d results, %0d with overflow,",
                 chars_sent, strings_sent, checked, overflows);
        $display("largest count seen %0d, mismatches %0d.", top_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("** palindromic_substring_counter_core: PASSED **");
        end else begin
            $display("** palindromic_substring_counter_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/psc_pkg.sv
hdl/psc_in_if.sv
hdl/psc_out_if.sv
hdl/psc_cell.sv
hdl/psc_tally.sv
hdl/palindromic_substring_counter_core.sv
tb/psc_count_checker.sv
tb/tb_palindromic_substring_counter_core.sv
